// ----- design/imm_pkg.sv -----
// shared types, constants and register codes for the ising multispin update block
// no dependencies; used by every module under design/

package imm_pkg;

    // data word: one bit per lane
    localparam int WORD_W = 64;
    localparam int LANES_DEF = 64;

    // acceptance thresholds are 53-bit fractions with one extra bit for "always"
    localparam int THR_W = 54;
    localparam int RND_W = 53;

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_ZERO = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_FOUR = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_EIGHT = 4'd3;

    localparam logic [THR_W-1:0] THR_ZERO_RST = 54'd9007199254740992;
    localparam logic [THR_W-1:0] THR_FOUR_RST = 54'd1218991862300000;
    localparam logic [THR_W-1:0] THR_EIGHT_RST = 54'd164972610000000;

    // splitmix64 finalizer constants
    localparam logic [WORD_W-1:0] SM_C1 = 64'hBF58476D1CE4E5B9;
    localparam logic [WORD_W-1:0] SM_C2 = 64'h94D049BB133111EB;
    localparam logic [WORD_W-1:0] SM_GOLDEN = 64'h9E3779B97F4A7C15;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
    } t_cfg;

    typedef struct packed {
        logic              busy;
        logic              load;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
    } t_seed;

    // one classified site, ready for the threshold compare
    typedef struct packed {
        logic [WORD_W-1:0] center;
        logic [WORD_W-1:0] low_align;
        logic [WORD_W-1:0] two;
        logic [WORD_W-1:0] three;
        logic [WORD_W-1:0] four;
        logic [RND_W-1:0]  rnd;
    } t_work;

endpackage

// ----- design/imm_mix.sv -----
// splitmix64 seed expansion: one shared 32x32 multiplier, three partial products per multiply
// depends on imm_pkg

module imm_mix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [imm_pkg::WORD_W-1:0]    i_seed,
    output imm_pkg::t_seed                o_seed
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_XS30 = 4'd1;
    localparam logic [3:0] ST_M1L = 4'd2;
    localparam logic [3:0] ST_M1H = 4'd3;
    localparam logic [3:0] ST_M1X = 4'd4;
    localparam logic [3:0] ST_XS27 = 4'd5;
    localparam logic [3:0] ST_M2L = 4'd6;
    localparam logic [3:0] ST_M2H = 4'd7;
    localparam logic [3:0] ST_M2X = 4'd8;
    localparam logic [3:0] ST_XS31 = 4'd9;

    logic [3:0]                   r_state, n_state;
    logic                         r_second;
    logic [imm_pkg::WORD_W-1:0]   r_seed, r_z, r_acc, r_word_a;
    logic [31:0]                  mul_x, mul_y;
    logic [63:0]                  product;
    logic [imm_pkg::WORD_W-1:0]   fin;

    // operand select: low*low, high*low, low*high (upper product bits drop out mod 2^64)
    always_comb begin
        mul_x = r_z[31:0];
        mul_y = imm_pkg::SM_C1[31:0];
        unique case (r_state)
            ST_M1L: begin mul_x = r_z[31:0];  mul_y = imm_pkg::SM_C1[31:0];  end
            ST_M1H: begin mul_x = r_z[63:32]; mul_y = imm_pkg::SM_C1[31:0];  end
            ST_M1X: begin mul_x = r_z[31:0];  mul_y = imm_pkg::SM_C1[63:32]; end
            ST_M2L: begin mul_x = r_z[31:0];  mul_y = imm_pkg::SM_C2[31:0];  end
            ST_M2H: begin mul_x = r_z[63:32]; mul_y = imm_pkg::SM_C2[31:0];  end
            ST_M2X: begin mul_x = r_z[31:0];  mul_y = imm_pkg::SM_C2[63:32]; end
            default: begin mul_x = r_z[31:0]; mul_y = imm_pkg::SM_C1[31:0];  end
        endcase
    end

    assign product = 64'(mul_x) * 64'(mul_y);
    assign fin = r_acc ^ (r_acc >> 31);

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = ST_IDLE;
            ST_XS30: n_state = ST_M1L;
            ST_M1L:  n_state = ST_M1H;
            ST_M1H:  n_state = ST_M1X;
            ST_M1X:  n_state = ST_XS27;
            ST_XS27: n_state = ST_M2L;
            ST_M2L:  n_state = ST_M2H;
            ST_M2H:  n_state = ST_M2X;
            ST_M2X:  n_state = ST_XS31;
            ST_XS31: n_state = r_second ? ST_IDLE : ST_XS30;
            default: n_state = ST_IDLE;
        endcase
    end

    // reset expands seed zero, just as a write of zero would
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_XS30;
            r_second <= 1'b0;
            r_seed <= '0;
            r_z <= '0;
        end else if (i_start) begin
            r_state <= ST_XS30;
            r_second <= 1'b0;
            r_seed <= i_seed;
            r_z <= i_seed;
        end else begin
            r_state <= n_state;
            case (r_state) inside
                ST_XS30: r_z <= r_z ^ (r_z >> 30);
                ST_M1L, ST_M2L: r_acc <= product;
                ST_M1H, ST_M1X, ST_M2H, ST_M2X: r_acc[63:32] <= r_acc[63:32] + product[31:0];
                ST_XS27: r_z <= r_acc ^ (r_acc >> 27);
                ST_XS31: begin
                    if (!r_second) begin
                        r_word_a <= fin;
                        r_z <= r_seed + imm_pkg::SM_GOLDEN;
                        r_second <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_seed.busy = (r_state != ST_IDLE);
    assign o_seed.load = (r_state == ST_XS31) && r_second;
    assign o_seed.word_a = r_word_a;
    assign o_seed.word_b = fin;

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_state == ST_XS30) && !r_second)
        else $error("seed write did not restart the expansion");

endmodule

// ----- design/imm_front.sv -----
// front end: accepts sites, counts aligned neighbors per lane, draws one xoroshiro128** number
// depends on imm_pkg and imm_mix

module imm_front #(
    parameter int LANES = imm_pkg::LANES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  imm_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [imm_pkg::WORD_W-1:0]    i_center_spins,
    input  logic [imm_pkg::WORD_W-1:0]    i_up_spins,
    input  logic [imm_pkg::WORD_W-1:0]    i_down_spins,
    input  logic [imm_pkg::WORD_W-1:0]    i_left_spins,
    input  logic [imm_pkg::WORD_W-1:0]    i_right_spins,
    input  logic                          i_q_full,
    output logic                          o_push,
    output imm_pkg::t_work                o_work
);

    localparam int W = imm_pkg::WORD_W;
    localparam logic [W-1:0] LaneMask = {W{1'b1}} >> (W - LANES);

    imm_pkg::t_seed seed;
    logic [W-1:0]   r_word_a, r_word_b;
    logic [W-1:0]   au, ad, al, ar;
    logic [W-1:0]   s_ud, c_ud, s_lr, c_lr, c_mid, b0, b1, b2;
    logic [W-1:0]   mul5, rot7, res, s1;
    logic           accept;

    imm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg.we && (i_cfg.index == imm_pkg::REG_SEED)),
        .i_seed  (i_cfg.data),
        .o_seed  (seed)
    );

    assign o_in_stall = seed.busy || i_q_full;
    assign accept = i_in_valid && !o_in_stall;
    assign o_push = accept;

    // per lane aligned count b2 b1 b0 from two half adders and a carry merge
    assign au = ~(i_center_spins ^ i_up_spins);
    assign ad = ~(i_center_spins ^ i_down_spins);
    assign al = ~(i_center_spins ^ i_left_spins);
    assign ar = ~(i_center_spins ^ i_right_spins);
    assign s_ud = au ^ ad;
    assign c_ud = au & ad;
    assign s_lr = al ^ ar;
    assign c_lr = al & ar;
    assign b0 = s_ud ^ s_lr;
    assign c_mid = s_ud & s_lr;
    assign b1 = c_mid ^ c_ud ^ c_lr;
    assign b2 = (c_ud & c_lr) | (c_lr & c_mid) | (c_ud & c_mid);

    // xoroshiro128** output: rotl(a*5, 7)*9 as shift-adds
    assign mul5 = r_word_a + (r_word_a << 2);
    assign rot7 = {mul5[W-8:0], mul5[W-1:W-7]};
    assign res = rot7 + (rot7 << 3);
    assign s1 = r_word_b ^ r_word_a;

    assign o_work.center = i_center_spins;
    assign o_work.low_align = ~b1 & ~b2 & LaneMask;
    assign o_work.two = ~b0 & b1 & ~b2 & LaneMask;
    assign o_work.three = b0 & b1 & ~b2 & LaneMask;
    assign o_work.four = ~b0 & ~b1 & b2 & LaneMask;
    assign o_work.rnd = res[W-1:W-imm_pkg::RND_W];

    always_ff @(posedge i_clk) begin
        if (seed.load) begin
            r_word_a <= seed.word_a;
            r_word_b <= seed.word_b;
        end else if (accept) begin
            r_word_a <= {r_word_a[39:0], r_word_a[63:40]} ^ s1 ^ (s1 << 16);
            r_word_b <= {s1[26:0], s1[63:27]};
        end
    end

    a_no_push_while_seeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seed.busy |-> !o_push)
        else $error("site accepted while generator seeding");

endmodule

// ----- design/imm_fifo.sv -----
// short queue of classified sites between front and back
// depends on imm_pkg

module imm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  imm_pkg::t_work  i_data,
    output logic            o_full,
    output logic            o_valid,
    output imm_pkg::t_work  o_data,
    input  logic            i_pop
);

    localparam int Depth = imm_pkg::QDEPTH;
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    imm_pkg::t_work     r_mem [Depth];
    logic [PtrW-1:0]    r_wr, r_rd;
    logic [CntW-1:0]    r_count;

    assign o_full = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10: r_count <= r_count + 1'b1;
                2'b01: r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("queue pushed when full or popped when empty");

endmodule

// ----- design/imm_back.sv -----
// back end: threshold registers, per-lane accept and the output register
// depends on imm_pkg

module imm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  imm_pkg::t_cfg                 i_cfg,
    input  logic                          i_q_valid,
    input  imm_pkg::t_work                i_work,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [imm_pkg::WORD_W-1:0]    o_new_center_spins,
    output logic [imm_pkg::WORD_W-1:0]    o_flipped_lanes
);

    localparam int W = imm_pkg::WORD_W;
    localparam int TW = imm_pkg::THR_W;

    logic [TW-1:0]  r_thr_zero, r_thr_four, r_thr_eight;
    logic           r_out_valid;
    logic [W-1:0]   r_new_center, r_flipped;
    logic [TW-1:0]  rnd;
    logic [W-1:0]   flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_zero <= imm_pkg::THR_ZERO_RST;
            r_thr_four <= imm_pkg::THR_FOUR_RST;
            r_thr_eight <= imm_pkg::THR_EIGHT_RST;
        end else if (i_cfg.we) begin
            if (i_cfg.index == imm_pkg::REG_ACC_ZERO) begin
                r_thr_zero <= i_cfg.data[TW-1:0];
            end
            if (i_cfg.index == imm_pkg::REG_ACC_FOUR) begin
                r_thr_four <= i_cfg.data[TW-1:0];
            end
            if (i_cfg.index == imm_pkg::REG_ACC_EIGHT) begin
                r_thr_eight <= i_cfg.data[TW-1:0];
            end
        end
    end

    assign rnd = {1'b0, i_work.rnd};
    assign flip = i_work.low_align
                | ((rnd < r_thr_zero) ? i_work.two : '0)
                | ((rnd < r_thr_four) ? i_work.three : '0)
                | ((rnd < r_thr_eight) ? i_work.four : '0);

    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_new_center <= i_work.center ^ flip;
            r_flipped <= flip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_center_spins = r_new_center;
    assign o_flipped_lanes = r_flipped;

    a_pop_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped site did not reach the output register");

endmodule

// ----- design/ising_multispin_metropolis_update_top.sv -----
// top level of the ising multispin metropolis site update
// depends on imm_pkg, imm_front (with imm_mix), imm_fifo and imm_back
//
//  channel   direction  handshake                   beat contents
//  --------  ---------  --------------------------  -------------------------------------
//  input     in         i_in_valid / o_in_stall     center, up, down, left, right spins
//  output    out        o_out_valid / i_out_stall   new center spins, flipped lanes
//  config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_wdata
//
//  one site per cycle unless stalled; beats go through the queue to the output register
//  a seed write (and reset, which expands seed zero) holds o_in_stall high through
//  two splitmix64 passes, each two multiplies of three partial products on one 32x32 unit
//  a two-entry queue sits between the front and the output register, so the front keeps
//  taking beats until the queue fills while i_out_stall is high

module ising_multispin_metropolis_update_top #(
    parameter int LANES = imm_pkg::LANES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [imm_pkg::WORD_W-1:0]        i_center_spins,
    input  logic [imm_pkg::WORD_W-1:0]        i_up_spins,
    input  logic [imm_pkg::WORD_W-1:0]        i_down_spins,
    input  logic [imm_pkg::WORD_W-1:0]        i_left_spins,
    input  logic [imm_pkg::WORD_W-1:0]        i_right_spins,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [imm_pkg::WORD_W-1:0]        o_new_center_spins,
    output logic [imm_pkg::WORD_W-1:0]        o_flipped_lanes,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [imm_pkg::WORD_W-1:0]        i_cfg_wdata
);

    imm_pkg::t_cfg  cfg;
    imm_pkg::t_work push_work, pop_work;
    logic           push, pop, q_full, q_valid;

    // config fans out to both halves; each picks its own registers
    assign cfg.we = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data = i_cfg_wdata;

    // front: neighbor count per lane, one random draw per taken beat
    imm_front #(
        .LANES (LANES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_center_spins (i_center_spins),
        .i_up_spins     (i_up_spins),
        .i_down_spins   (i_down_spins),
        .i_left_spins   (i_left_spins),
        .i_right_spins  (i_right_spins),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_work         (push_work)
    );

    // queue decouples the front stall from the output stall
    imm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_work),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (pop_work),
        .i_pop   (pop)
    );

    // back: three threshold compares, flip mask and output register
    imm_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_q_valid          (q_valid),
        .i_work             (pop_work),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_new_center_spins (o_new_center_spins),
        .o_flipped_lanes    (o_flipped_lanes)
    );

endmodule

// ----- tb/tb_ising_multispin_metropolis_update_top.sv -----
// self-checking testbench for the ising multispin metropolis site update block
// depends on imm_pkg and ising_multispin_metropolis_update_top; predicts every site
// in its own xoroshiro128** / splitmix64 model and checks each output beat in order

module tb_ising_multispin_metropolis_update_top;

    localparam int W = imm_pkg::WORD_W;
    localparam int CLK_HALF = 10;
    localparam int RESET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_GUARD = 20000;
    localparam int PHASES = 6;
    localparam int SITES_PER_PHASE = 200;

    // indexes outside the register map, the block must ignore writes to them
    localparam logic [imm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd4;
    localparam logic [imm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

    localparam logic [imm_pkg::THR_W-1:0] THR_ALWAYS = 54'd1 << imm_pkg::RND_W;

    typedef struct packed {
        logic [W-1:0] center;
        logic [W-1:0] up;
        logic [W-1:0] down;
        logic [W-1:0] left;
        logic [W-1:0] right;
    } t_site_in;

    typedef struct packed {
        logic [W-1:0] new_center;
        logic [W-1:0] flipped;
    } t_site_out;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic [W-1:0]                      i_center_spins;
    logic [W-1:0]                      i_up_spins;
    logic [W-1:0]                      i_down_spins;
    logic [W-1:0]                      i_left_spins;
    logic [W-1:0]                      i_right_spins;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [W-1:0]                      o_new_center_spins;
    logic [W-1:0]                      o_flipped_lanes;
    logic                              i_cfg_we;
    logic [imm_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [W-1:0]                      i_cfg_wdata;

    // predictor state: generator words and thresholds as the block should hold them
    logic [W-1:0]                 rng_a;
    logic [W-1:0]                 rng_b;
    logic [imm_pkg::THR_W-1:0]    thr_zero;
    logic [imm_pkg::THR_W-1:0]    thr_four;
    logic [imm_pkg::THR_W-1:0]    thr_eight;

    t_site_out expected_sites[$];

    int mismatches;
    int sites_sent;
    int results_checked;
    int reg_writes;
    int in_stall_cycles;
    int flip_lanes_seen;

    // idling controls shared by the stimulus and the receiver process
    bit tx_quiet;
    bit rx_quiet;
    int rx_hold_req;

    ising_multispin_metropolis_update_top #(
        .LANES(imm_pkg::LANES_DEF)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_center_spins     (i_center_spins),
        .i_up_spins         (i_up_spins),
        .i_down_spins       (i_down_spins),
        .i_left_spins       (i_left_spins),
        .i_right_spins      (i_right_spins),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_new_center_spins (o_new_center_spins),
        .o_flipped_lanes    (o_flipped_lanes),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("%0t: timeout, %0d beats still outstanding", $time, expected_sites.size());
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [W-1:0] rotl64(input logic [W-1:0] v, input int k);
        return (v << k) | (v >> (W - k));
    endfunction

    function automatic logic [W-1:0] splitmix_finish(input logic [W-1:0] v);
        logic [W-1:0] z;
        z = (v ^ (v >> 30)) * imm_pkg::SM_C1;
        z = (z ^ (z >> 27)) * imm_pkg::SM_C2;
        return z ^ (z >> 31);
    endfunction

    function automatic void seed_generator(input logic [W-1:0] seed);
        rng_a = splitmix_finish(seed);
        rng_b = splitmix_finish(seed + imm_pkg::SM_GOLDEN);
    endfunction

    // one xoroshiro128** step, returns the top 53 bits
    function automatic logic [imm_pkg::RND_W-1:0] next_fraction();
        logic [W-1:0] s0;
        logic [W-1:0] s1;
        logic [W-1:0] raw;
        s0 = rng_a;
        s1 = rng_b;
        raw = rotl64(s0 * 64'd5, 7) * 64'd9;
        s1 = s1 ^ s0;
        rng_a = rotl64(s0, 24) ^ s1 ^ (s1 << 16);
        rng_b = rotl64(s1, 37);
        return raw[W-1:W-imm_pkg::RND_W];
    endfunction

    function automatic t_site_out predict_site(input t_site_in s);
        logic [imm_pkg::RND_W-1:0] frac;
        logic                      pass_zero;
        logic                      pass_four;
        logic                      pass_eight;
        logic [W-1:0]              flips;
        int                        aligned;
        t_site_out                 res;
        frac = next_fraction();
        pass_zero = {1'b0, frac} < thr_zero;
        pass_four = {1'b0, frac} < thr_four;
        pass_eight = {1'b0, frac} < thr_eight;
        flips = '0;
        for (int k = 0; k < W; k++) begin
            aligned = int'(s.up[k] == s.center[k]) + int'(s.down[k] == s.center[k])
                    + int'(s.left[k] == s.center[k]) + int'(s.right[k] == s.center[k]);
            case (aligned)
                0, 1: flips[k] = 1'b1;      // energy drops, always flips
                2: flips[k] = pass_zero;
                3: flips[k] = pass_four;
                default: flips[k] = pass_eight;
            endcase
            if (k >= imm_pkg::LANES_DEF) begin
                flips[k] = 1'b0;
            end
        end
        res.flipped = flips;
        res.new_center = s.center ^ flips;
        return res;
    endfunction

    // ---------------------------------------------------------------- receiver

    // random stall bursts, mostly short; a requested hold-off overrides everything
    always @(posedge i_clk) begin : rx_stall_gen
        int hold_left;
        int burst_left;
        int pick;
        if (rx_hold_req != 0) begin
            hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (rx_quiet) begin
            i_out_stall <= 1'b0;
        end else if (burst_left > 0) begin
            i_out_stall <= 1'b1;
            burst_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                i_out_stall <= 1'b0;
            end else if (pick < 95) begin
                i_out_stall <= 1'b1;
                burst_left = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                burst_left = $urandom_range(8, 40);
            end
        end
    end

    // compares every accepted output beat against the oldest prediction
    always @(posedge i_clk) begin : beat_checker
        t_site_out want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_sites.size() == 0) begin
                $display("%0t: output beat with nothing expected, new_center %h flipped %h",
                         $time, o_new_center_spins, o_flipped_lanes);
                mismatches++;
            end else begin
                want = expected_sites.pop_front();
                results_checked++;
                flip_lanes_seen += $countones(want.flipped);
                if (o_new_center_spins !== want.new_center) begin
                    $display("%0t: new_center_spins expected %h actual %h",
                             $time, want.new_center, o_new_center_spins);
                    mismatches++;
                end
                if (o_flipped_lanes !== want.flipped) begin
                    $display("%0t: flipped_lanes expected %h actual %h",
                             $time, want.flipped, o_flipped_lanes);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sender side

    function automatic logic [W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random site, often close to aligned so the thresholds decide
    function automatic t_site_in random_site();
        t_site_in s;
        int       style;
        s.center = rand64();
        style = $urandom_range(0, 9);
        if (style < 5) begin
            s.up = rand64();
            s.down = rand64();
            s.left = rand64();
            s.right = rand64();
        end else if (style < 8) begin
            s.up = s.center ^ (rand64() & rand64());
            s.down = s.center ^ (rand64() & rand64());
            s.left = s.center ^ (rand64() & rand64());
            s.right = s.center ^ (rand64() & rand64());
        end else begin
            s.up = ~s.center ^ (rand64() & rand64());
            s.down = ~s.center ^ (rand64() & rand64());
            s.left = ~s.center ^ (rand64() & rand64());
            s.right = ~s.center ^ (rand64() & rand64());
        end
        return s;
    endfunction

    // neighbor patterns that give every aligned count 0..4 across the lanes
    function automatic t_site_in spread_site(input logic [W-1:0] center);
        t_site_in s;
        s.center = center;
        s.up = center ^ 64'h5555_5555_5555_5555;
        s.down = center ^ 64'h3333_3333_3333_3333;
        s.left = center ^ 64'h0F0F_0F0F_0F0F_0F0F;
        s.right = center ^ 64'h00FF_00FF_00FF_00FF;
        return s;
    endfunction

    function automatic t_site_in uniform_site(input logic [W-1:0] center,
                                              input logic [W-1:0] nbr);
        t_site_in s;
        s.center = center;
        s.up = nbr;
        s.down = nbr;
        s.left = nbr;
        s.right = nbr;
        return s;
    endfunction

    function automatic int tx_gap();
        int pick;
        if (tx_quiet) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 50);
    endfunction

    // called at a rising edge; returns at the edge where the beat was taken
    task automatic send_site(input t_site_in s);
        i_in_valid <= 1'b1;
        i_center_spins <= s.center;
        i_up_spins <= s.up;
        i_down_spins <= s.down;
        i_left_spins <= s.left;
        i_right_spins <= s.right;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            in_stall_cycles++;
            @(posedge i_clk);
        end
        expected_sites.push_back(predict_site(s));
        sites_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_random_sites(input int count);
        for (int n = 0; n < count; n++) begin
            send_site(random_site());
            idle_sender(tx_gap());
        end
    endtask

    // sender pauses until every predicted beat has come out
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_sites.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // register write while the block is idle; a seed write restarts the expansion
    task automatic write_reg(input logic [imm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [W-1:0] data);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_writes++;
        case (idx)
            imm_pkg::REG_SEED: seed_generator(data);
            imm_pkg::REG_ACC_ZERO: thr_zero = data[imm_pkg::THR_W-1:0];
            imm_pkg::REG_ACC_FOUR: thr_four = data[imm_pkg::THR_W-1:0];
            imm_pkg::REG_ACC_EIGHT: thr_eight = data[imm_pkg::THR_W-1:0];
            default: ;
        endcase
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_all_thresholds(input logic [W-1:0] value);
        write_reg(imm_pkg::REG_ACC_ZERO, value);
        write_reg(imm_pkg::REG_ACC_FOUR, value);
        write_reg(imm_pkg::REG_ACC_EIGHT, value);
    endtask

    function automatic logic [W-1:0] random_threshold();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return W'(THR_ALWAYS);
            2: return rand64();                               // high bits dropped
            3: return W'($urandom_range(0, 1 << 20));
            default: return rand64() & ((64'd1 << imm_pkg::RND_W) - 1);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // reset values: zero change always accepted, the other two by chance
    task automatic test_reset_defaults();
        send_site(uniform_site('0, '0));
        send_site(uniform_site('1, '0));
        send_site(spread_site('0));
        send_site(spread_site('1));
        send_site(uniform_site(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        wait_drain();
    endtask

    // never, exactly always, above always, unmapped indexes, seed corners
    task automatic test_register_extremes();
        write_all_thresholds('0);
        send_site(spread_site('0));
        send_site(spread_site(64'hDEAD_BEEF_0123_4567));
        send_site(uniform_site('1, '1));
        wait_drain();
        write_all_thresholds(W'(THR_ALWAYS));
        send_site(spread_site('1));
        send_site(uniform_site('0, '0));
        wait_drain();
        write_all_thresholds('1);
        send_site(spread_site('0));
        send_site(uniform_site(64'hF0F0_F0F0_F0F0_F0F0, 64'hF0F0_F0F0_F0F0_F0F0));
        wait_drain();
        write_reg(imm_pkg::REG_ACC_FOUR, 64'd3);
        write_reg(REG_UNMAPPED_LO, '0);
        write_reg(REG_UNMAPPED_HI, '1);
        send_site(spread_site('0));
        send_site(spread_site('1));
        wait_drain();
        write_reg(imm_pkg::REG_SEED, '1);
        send_site(spread_site('0));
        send_site(spread_site('1));
        wait_drain();
        write_reg(imm_pkg::REG_SEED, -imm_pkg::SM_GOLDEN);    // second word seeded from zero
        send_site(spread_site('0));
        send_site(random_site());
        wait_drain();
        write_reg(imm_pkg::REG_SEED, '0);
        send_site(spread_site('0));
        send_site(random_site());
        wait_drain();
    endtask

    // new seed and thresholds per phase; some phases run without idling on one side
    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            wait_drain();
            write_reg(imm_pkg::REG_SEED, rand64());
            write_reg(imm_pkg::REG_ACC_ZERO, random_threshold());
            write_reg(imm_pkg::REG_ACC_FOUR, random_threshold());
            write_reg(imm_pkg::REG_ACC_EIGHT, random_threshold());
            tx_quiet = (p % 3 == 1);
            rx_quiet = (p % 3 == 2);
            send_random_sites(SITES_PER_PHASE);
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_drain();
    endtask

    // long receiver hold while beats keep coming, so the queue fills and stalls input
    task automatic test_backpressure();
        tx_quiet = 1'b1;
        rx_hold_req = 250;
        send_random_sites(40);
        tx_quiet = 1'b0;
        wait_drain();
    endtask

    // bursts separated by full drains
    task automatic test_drain_pauses();
        for (int n = 0; n < 3; n++) begin
            send_random_sites(15);
            wait_drain();
        end
    endtask

    task automatic finish_run();
        int guard;
        i_in_valid <= 1'b0;
        guard = 0;
        while (expected_sites.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_sites.size() != 0) begin
            $display("%0t: %0d predicted beats never came out", $time, expected_sites.size());
            mismatches += expected_sites.size();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_center_spins <= '0;
        i_up_spins <= '0;
        i_down_spins <= '0;
        i_left_spins <= '0;
        i_right_spins <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= imm_pkg::REG_SEED;
        i_cfg_wdata <= '0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        rx_hold_req = 0;
        mismatches = 0;
        sites_sent = 0;
        results_checked = 0;
        reg_writes = 0;
        in_stall_cycles = 0;
        flip_lanes_seen = 0;
        thr_zero = imm_pkg::THR_ZERO_RST;
        thr_four = imm_pkg::THR_FOUR_RST;
        thr_eight = imm_pkg::THR_EIGHT_RST;
        seed_generator('0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_phases();
        test_drain_pauses();
        finish_run();

        $display("sent %0d sites, checked %0d beats, %0d lanes flipped", sites_sent,
                 results_checked, flip_lanes_seen);
        $display("%0d register writes, %0d cycles with the input stalled", reg_writes,
                 in_stall_cycles);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
